// ===== hw/rtl/ecalu_pkg.sv =====
package ecalu_pkg;

  // Flag bit positions within a four-bit flag word
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_RLC   = 5'd10,
    OP_RRC   = 5'd11,
    OP_RL    = 5'd12,
    OP_RR    = 5'd13,
    OP_SLA   = 5'd14,
    OP_SRA   = 5'd15,
    OP_SRL   = 5'd16,
    OP_SWAP  = 5'd17,
    OP_BIT   = 5'd18,
    OP_RES   = 5'd19,
    OP_SET   = 5'd20,
    OP_ADDHL = 5'd21,
    OP_ADDSP = 5'd22
  } op_e;

  typedef struct packed {
    logic [4:0]  func;
    logic [7:0]  acc;
    logic [15:0] wide_reg;
    logic [15:0] operand;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  byte_result;
    logic [15:0] wide_result;
    logic [3:0]  flags_out;
  } result_t;

endpackage

// ===== hw/rtl/ecalu_core.sv =====
module ecalu_core import ecalu_pkg::*; (
  input  cmd_t    cmd,
  output result_t result
);

  logic [7:0]  a;
  logic [7:0]  v;
  logic [15:0] w;
  logic [15:0] op16;
  logic        cin;
  logic        cx;
  logic [8:0]  sum9;
  logic [4:0]  sum_lo;
  logic [7:0]  diff;
  logic        h_sub;
  logic        c_sub;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [15:0] sp_sum;
  logic [4:0]  sp_lo4;
  logic [8:0]  sp_lo8;
  logic [7:0]  r;
  logic [7:0]  mask;

  assign a    = cmd.acc;
  assign v    = cmd.operand[7:0];
  assign w    = cmd.wide_reg;
  assign op16 = cmd.operand;
  assign cin  = cmd.flags_in[FlagC];
  assign mask = 8'(8'd1 << cmd.bit_index);

  // Carry-in only for adc and sbc
  assign cx = ((cmd.func == OP_ADC) || (cmd.func == OP_SBC)) ? cin : 1'b0;

  assign sum9   = {1'b0, a} + {1'b0, v} + {8'd0, cx};
  assign sum_lo = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cx};
  assign diff   = a - v - {7'd0, cx};
  assign h_sub  = ({1'b0, v[3:0]} + {4'd0, cx}) > {1'b0, a[3:0]};
  assign c_sub  = ({1'b0, v} + {8'd0, cx}) > {1'b0, a};

  assign sum17  = {1'b0, w} + {1'b0, op16};
  assign sum13  = {1'b0, w[11:0]} + {1'b0, op16[11:0]};
  assign sp_sum = w + {{8{v[7]}}, v};
  assign sp_lo4 = {1'b0, w[3:0]} + {1'b0, v[3:0]};
  assign sp_lo8 = {1'b0, w[7:0]} + {1'b0, v};

  always_comb begin
    r = cmd.acc;
    result.byte_result = cmd.acc;
    result.wide_result = 16'd0;
    result.flags_out   = cmd.flags_in;
    case (op_e'(cmd.func))
      OP_ADD, OP_ADC: begin
        r = sum9[7:0];
        result.byte_result = r;
        result.flags_out = {r == 8'd0, 1'b0, sum_lo[4], sum9[8]};
      end
      OP_SUB, OP_SBC: begin
        r = diff;
        result.byte_result = r;
        result.flags_out = {r == 8'd0, 1'b1, h_sub, c_sub};
      end
      OP_CP: begin
        result.flags_out = {diff == 8'd0, 1'b1, h_sub, c_sub};
      end
      OP_AND: begin
        r = a & v;
        result.byte_result = r;
        result.flags_out = {r == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        r = a ^ v;
        result.byte_result = r;
        result.flags_out = {r == 8'd0, 3'b000};
      end
      OP_OR: begin
        r = a | v;
        result.byte_result = r;
        result.flags_out = {r == 8'd0, 3'b000};
      end
      OP_INC: begin
        r = v + 8'd1;
        result.byte_result = r;
        result.flags_out = {r == 8'd0, 1'b0, v[3:0] == 4'hf, cin};
      end
      OP_DEC: begin
        r = v - 8'd1;
        result.byte_result = r;
        result.flags_out = {r == 8'd0, 1'b1, v[3:0] == 4'h0, cin};
      end
      OP_RLC: begin
        r = {v[6:0], v[7]};
        result.byte_result = r;
        result.flags_out = {r == 8'd0, 2'b00, v[7]};
      end
      OP_RRC: begin
        r = {v[0], v[7:1]};
        result.byte_result = r;
        result.flags_out = {r == 8'd0, 2'b00, v[0]};
      end
      OP_RL: begin
        r = {v[6:0], cin};
        result.byte_result = r;
        result.flags_out = {r == 8'd0, 2'b00, v[7]};
      end
      OP_RR: begin
        r = {cin, v[7:1]};
        result.byte_result = r;
        result.flags_out = {r == 8'd0, 2'b00, v[0]};
      end
      OP_SLA: begin
        r = {v[6:0], 1'b0};
        result.byte_result = r;
        result.flags_out = {r == 8'd0, 2'b00, v[7]};
      end
      OP_SRA: begin
        r = {v[7], v[7:1]};
        result.byte_result = r;
        result.flags_out = {r == 8'd0, 2'b00, v[0]};
      end
      OP_SRL: begin
        r = {1'b0, v[7:1]};
        result.byte_result = r;
        result.flags_out = {r == 8'd0, 2'b00, v[0]};
      end
      OP_SWAP: begin
        r = {v[3:0], v[7:4]};
        result.byte_result = r;
        result.flags_out = {r == 8'd0, 3'b000};
      end
      OP_BIT: begin
        result.flags_out = {~v[cmd.bit_index], 1'b0, 1'b1, cin};
      end
      OP_RES: begin
        result.byte_result = v & ~mask;
      end
      OP_SET: begin
        result.byte_result = v | mask;
      end
      OP_ADDHL: begin
        result.byte_result = 8'd0;
        result.wide_result = sum17[15:0];
        result.flags_out = {cmd.flags_in[FlagZ], 1'b0, sum13[12], sum17[16]};
      end
      OP_ADDSP: begin
        result.byte_result = 8'd0;
        result.wide_result = sp_sum;
        result.flags_out = {2'b00, sp_lo4[4], sp_lo8[8]};
      end
      default: begin
        result.byte_result = cmd.acc;
      end
    endcase
  end

endmodule

// ===== hw/rtl/eight_bit_cpu_alu_with_flags.sv =====
// Eight-bit ALU with zero, subtract, half-carry and carry flags. A word is
// taken on every edge where start is high; busy is always low, so one
// operation can be issued every cycle. Each word passes an input register and
// a result register before its result appears on result for exactly one
// cycle with done high. The receiver cannot stall: results must be captured in
// the cycle that done marks.
module eight_bit_cpu_alu_with_flags import ecalu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result
);

  logic    in_valid;
  cmd_t    in_reg;
  result_t core_out;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start;
      done     <= in_valid;
    end
  end

  // Payload registers: capture unconditionally, validity travels alongside
  always_ff @(posedge clk) begin
    in_reg <= cmd;
    result <= core_out;
  end

  ecalu_core u_core (
    .cmd    (in_reg),
    .result (core_out)
  );

`ifndef NO_ASSERTIONS
  a_two_cycle_latency: assert property (@(posedge clk) disable iff (rst)
    start |=> ##1 done)
    else $error("accepted word produced no strobe two cycles later");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2))
    else $error("strobe without an accepted word");

  a_byte_ops_no_wide: assert property (@(posedge clk) disable iff (rst)
    (done && $past(in_reg.func) != OP_ADDHL && $past(in_reg.func) != OP_ADDSP)
      |-> result.wide_result == 16'd0)
    else $error("wide result not zero for an eight-bit operation");

  a_wide_ops_no_byte: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(in_reg.func) == OP_ADDHL || $past(in_reg.func) == OP_ADDSP))
      |-> result.byte_result == 8'd0)
    else $error("byte result not zero for a sixteen-bit operation");
`endif

endmodule

// ===== verif/alu_result_check.sv =====
`timescale 1ns / 100ps

module alu_result_check import ecalu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  cmd_t        cmd,
  input  logic        done,
  input  result_t     result,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  localparam int unsigned ReportLimit = 10;

  result_t expected_q[$];

  function automatic logic [3:0] make_flags(input logic z, input logic n, input logic h,
                                            input logic c);
    logic [3:0] f;
    f        = 4'h0;
    f[FlagZ] = z;
    f[FlagN] = n;
    f[FlagH] = h;
    f[FlagC] = c;
    return f;
  endfunction

  function automatic result_t alu_eval(input cmd_t c);
    result_t     res;
    logic [7:0]  a;
    logic [7:0]  v;
    logic [7:0]  r;
    logic        cin;
    logic        cy;
    logic [8:0]  sum9;
    logic [16:0] sum17;
    a   = c.acc;
    v   = c.operand[7:0];
    cin = c.flags_in[FlagC];
    res.byte_result = 8'h00;
    res.wide_result = 16'h0000;
    res.flags_out   = c.flags_in;
    case (c.func)
      OP_ADD, OP_ADC: begin
        cy   = (c.func == OP_ADC) ? cin : 1'b0;
        sum9 = {1'b0, a} + {1'b0, v} + {8'h00, cy};
        res.byte_result = sum9[7:0];
        res.flags_out = make_flags(sum9[7:0] == 8'h00, 1'b0,
                                   ({1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'h0, cy}) > 5'h0f,
                                   sum9[8]);
      end
      OP_SUB, OP_SBC, OP_CP: begin
        cy = (c.func == OP_SBC) ? cin : 1'b0;
        r  = a - v - {7'h00, cy};
        res.byte_result = (c.func == OP_CP) ? a : r;
        res.flags_out = make_flags(r == 8'h00, 1'b1,
                                   ({1'b0, v[3:0]} + {4'h0, cy}) > {1'b0, a[3:0]},
                                   ({1'b0, v} + {8'h00, cy}) > {1'b0, a});
      end
      OP_AND: begin
        r = a & v;
        res.byte_result = r;
        res.flags_out = make_flags(r == 8'h00, 1'b0, 1'b1, 1'b0);
      end
      OP_XOR, OP_OR: begin
        r = (c.func == OP_XOR) ? (a ^ v) : (a | v);
        res.byte_result = r;
        res.flags_out = make_flags(r == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_INC: begin
        r = v + 8'h01;
        res.byte_result = r;
        res.flags_out = make_flags(r == 8'h00, 1'b0, v[3:0] == 4'hf, cin);
      end
      OP_DEC: begin
        r = v - 8'h01;
        res.byte_result = r;
        res.flags_out = make_flags(r == 8'h00, 1'b1, v[3:0] == 4'h0, cin);
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SRL: begin
        case (c.func)
          OP_RLC:  r = {v[6:0], v[7]};
          OP_RRC:  r = {v[0], v[7:1]};
          OP_RL:   r = {v[6:0], cin};
          OP_RR:   r = {cin, v[7:1]};
          OP_SLA:  r = {v[6:0], 1'b0};
          OP_SRA:  r = {v[7], v[7:1]};
          default: r = {1'b0, v[7:1]};
        endcase
        // left moves shift out bit 7, right moves bit 0
        cy = (c.func == OP_RLC || c.func == OP_RL || c.func == OP_SLA) ? v[7] : v[0];
        res.byte_result = r;
        res.flags_out = make_flags(r == 8'h00, 1'b0, 1'b0, cy);
      end
      OP_SWAP: begin
        r = {v[3:0], v[7:4]};
        res.byte_result = r;
        res.flags_out = make_flags(r == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_BIT: begin
        res.byte_result = a;
        res.flags_out = make_flags(~v[c.bit_index], 1'b0, 1'b1, cin);
      end
      OP_RES: res.byte_result = v & ~(8'h01 << c.bit_index);
      OP_SET: res.byte_result = v | (8'h01 << c.bit_index);
      OP_ADDHL: begin
        sum17 = {1'b0, c.wide_reg} + {1'b0, c.operand};
        res.wide_result = sum17[15:0];
        res.flags_out = make_flags(c.flags_in[FlagZ], 1'b0,
                                   ({1'b0, c.wide_reg[11:0]} + {1'b0, c.operand[11:0]})
                                     > 13'h0fff,
                                   sum17[16]);
      end
      OP_ADDSP: begin
        sum17 = {1'b0, c.wide_reg} + {1'b0, {8{v[7]}}, v};
        sum9  = {1'b0, c.wide_reg[7:0]} + {1'b0, v};
        res.wide_result = sum17[15:0];
        res.flags_out = make_flags(1'b0, 1'b0,
                                   ({1'b0, c.wide_reg[3:0]} + {1'b0, v[3:0]}) > 5'h0f,
                                   sum9[8]);
      end
      default: res.byte_result = a;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst) begin
      if (done) begin
        if (expected_q.size() == 0) begin
          if (mismatches < ReportLimit)
            $display("%0t: result word with none expected: byte %02h wide %04h flags %01h",
                     $time, result.byte_result, result.wide_result, result.flags_out);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_q.pop_front();
          if (result.byte_result !== want.byte_result ||
              result.wide_result !== want.wide_result ||
              result.flags_out !== want.flags_out) begin
            if (mismatches < ReportLimit)
              $display("%0t: mismatch: byte %02h/%02h wide %04h/%04h flags %01h/%01h (exp/got)",
                       $time, want.byte_result, result.byte_result, want.wide_result,
                       result.wide_result, want.flags_out, result.flags_out);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (start && !busy)
        expected_q.push_back(alu_eval(cmd));
    end
    outstanding <= expected_q.size();
  end

endmodule

// ===== verif/tb_eight_bit_cpu_alu_with_flags.sv =====
`timescale 1ns / 100ps

module tb_eight_bit_cpu_alu_with_flags;
  import ecalu_pkg::*;

  localparam int unsigned RandomWords  = 1900;
  localparam int unsigned StallLimit   = 1000;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned ResetCycles  = 8;
  localparam logic [4:0]  FuncUnused   = 5'd31;

  logic        clk;
  logic        rst   = 1'b1;
  logic        start = 1'b0;
  cmd_t        cmd   = '0;
  logic        busy;
  logic        done;
  result_t     result;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned stall_count = 0;

  eight_bit_cpu_alu_with_flags u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  alu_result_check u_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // End the run if no word moves in either direction for too long
  always @(posedge clk) begin
    if ((start && !busy) || done)
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic cmd_t make_cmd(input logic [4:0] func, input logic [7:0] acc,
                                    input logic [15:0] wide_reg, input logic [15:0] operand,
                                    input logic [2:0] bit_index, input logic [3:0] flags_in);
    cmd_t c;
    c.func      = func;
    c.acc       = acc;
    c.wide_reg  = wide_reg;
    c.operand   = operand;
    c.bit_index = bit_index;
    c.flags_in  = flags_in;
    return c;
  endfunction

  // Lean towards the nibble and sign boundaries where the flags change
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0:       b = 8'h00;
      1:       b = 8'hff;
      2:       b = 8'h0f;
      3:       b = 8'h10;
      4:       b = 8'h80;
      5:       b = 8'h7f;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    if ($urandom_range(0, 9) == 0)
      c.func = 5'($urandom_range(0, 31));
    else
      c.func = 5'($urandom_range(0, OP_ADDSP));
    c.acc       = pick_byte();
    c.wide_reg  = {pick_byte(), pick_byte()};
    c.operand   = {pick_byte(), pick_byte()};
    c.bit_index = 3'($urandom_range(0, 7));
    c.flags_in  = 4'($urandom_range(0, 15));
    return c;
  endfunction

  task automatic issue(input cmd_t c, input int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      cmd   <= random_cmd();
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  cmd_t        directed_q[$];
  int unsigned idle_pct[3] = '{31, 82, 0};

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_q.push_back(make_cmd(OP_ADD,   8'hff, 16'h0000, 16'h0001, 3'd0, 4'h0));
    directed_q.push_back(make_cmd(OP_ADC,   8'h0f, 16'h0000, 16'hff00, 3'd0, 4'h1));
    directed_q.push_back(make_cmd(OP_SUB,   8'h00, 16'h0000, 16'h0001, 3'd0, 4'h0));
    directed_q.push_back(make_cmd(OP_SBC,   8'h10, 16'h0000, 16'h000f, 3'd0, 4'h1));
    directed_q.push_back(make_cmd(OP_AND,   8'h00, 16'h0000, 16'h00ff, 3'd0, 4'hf));
    directed_q.push_back(make_cmd(OP_XOR,   8'h5a, 16'h0000, 16'h005a, 3'd0, 4'hf));
    directed_q.push_back(make_cmd(OP_OR,    8'h00, 16'hffff, 16'hff00, 3'd0, 4'hf));
    directed_q.push_back(make_cmd(OP_CP,    8'h42, 16'h0000, 16'h0042, 3'd0, 4'h0));
    directed_q.push_back(make_cmd(OP_INC,   8'h00, 16'h0000, 16'h00ff, 3'd0, 4'h1));
    directed_q.push_back(make_cmd(OP_DEC,   8'h00, 16'h0000, 16'h0010, 3'd0, 4'h0));
    directed_q.push_back(make_cmd(OP_RLC,   8'h00, 16'h0000, 16'h0080, 3'd0, 4'h0));
    directed_q.push_back(make_cmd(OP_RRC,   8'h00, 16'h0000, 16'h0001, 3'd0, 4'h0));
    directed_q.push_back(make_cmd(OP_RL,    8'h00, 16'h0000, 16'h0080, 3'd0, 4'h0));
    directed_q.push_back(make_cmd(OP_RR,    8'h00, 16'h0000, 16'h0001, 3'd0, 4'h1));
    directed_q.push_back(make_cmd(OP_SLA,   8'h00, 16'h0000, 16'h0080, 3'd0, 4'hf));
    directed_q.push_back(make_cmd(OP_SRA,   8'h00, 16'h0000, 16'h0081, 3'd0, 4'h0));
    directed_q.push_back(make_cmd(OP_SRL,   8'h00, 16'h0000, 16'h0001, 3'd0, 4'h0));
    directed_q.push_back(make_cmd(OP_SWAP,  8'h00, 16'h0000, 16'h00f0, 3'd0, 4'hf));
    directed_q.push_back(make_cmd(OP_BIT,   8'hc3, 16'h0000, 16'h007f, 3'd7, 4'h1));
    directed_q.push_back(make_cmd(OP_RES,   8'h00, 16'h0000, 16'h00ff, 3'd0, 4'ha));
    directed_q.push_back(make_cmd(OP_SET,   8'h00, 16'h0000, 16'h0000, 3'd7, 4'h5));
    directed_q.push_back(make_cmd(OP_ADDHL, 8'h00, 16'h0fff, 16'h0001, 3'd0, 4'h8));
    directed_q.push_back(make_cmd(OP_ADDHL, 8'h00, 16'hffff, 16'h0001, 3'd0, 4'h0));
    directed_q.push_back(make_cmd(OP_ADDSP, 8'h00, 16'h00ff, 16'h0001, 3'd0, 4'hf));
    directed_q.push_back(make_cmd(OP_ADDSP, 8'h00, 16'h0000, 16'h0080, 3'd0, 4'h0));
    directed_q.push_back(make_cmd(FuncUnused, 8'h99, 16'h1234, 16'h5678, 3'd3, 4'h6));

    foreach (directed_q[i])
      issue(directed_q[i], 0);

    // Three phases: moderate sender gaps, heavy gaps, then back to back
    for (int p = 0; p < 3; p++)
      for (int n = 0; n < RandomWords / 3; n++)
        issue(random_cmd(), idle_pct[p]);
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
